// ----- hw/rtl/lwcd_pkg.sv -----
// Shared types and codes for the LRU write-back cache directory.
package lwcd_pkg;
   localparam logic [1:0] KIND_GET_REFRESH = 2'd0;
   localparam logic [1:0] KIND_GET_PEEK    = 2'd1;
   localparam logic [1:0] KIND_PUT         = 2'd2;
   localparam logic [1:0] KIND_FLUSH       = 2'd3;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_READ   = 3'd1;
   localparam logic [2:0] ACT_FETCH  = 3'd2;
   localparam logic [2:0] ACT_DISK   = 3'd3;
   localparam logic [2:0] ACT_DEMOTE = 3'd4;

   localparam logic [1:0] REG_CAPACITY   = 2'd0;
   localparam logic [1:0] REG_NEXT_LEVEL = 2'd1;

   localparam int OUT_ID_BITS = 32;
   localparam int CFG_CAP_BITS = 5;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic refresh;   // move matched/new entry to rank 0 (others below it age)
      logic evict;     // drop the oldest valid cell
      logic insert;    // load new entry in the first free cell
      logic update;    // overwrite payload of matching cell
      logic clear;     // invalidate all
   } cell_cmd_type;
endpackage

// ----- hw/rtl/lwcd_cell.sv -----
// One directory cell: an entry with id, dirty mark, data, recency rank.
module lwcd_cell
   import lwcd_pkg::*;
#(
   parameter int ID_BITS = 32,
   parameter int DATA_BITS = 64,
   parameter int RANK_BITS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [ID_BITS-1:0]   key,
   input  logic                 dirty_new,
   input  logic [DATA_BITS-1:0] data_new,
   input  logic [RANK_BITS-1:0] ref_rank,
   input  logic                 sel_insert,
   input  logic                 sel_evict,
   input  logic                 sel_match,
   input  logic                 match_any,
   output logic                 valid,
   output logic                 match,
   output logic [RANK_BITS-1:0] rank,
   output logic [ID_BITS-1:0]   id,
   output logic                 dirty,
   output logic [DATA_BITS-1:0] data
);
   logic valid_ff, valid_in;
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic [ID_BITS-1:0] id_ff;
   logic dirty_ff;
   logic [DATA_BITS-1:0] data_ff;

   assign match = valid_ff && (id_ff == key);

   always_comb begin
      valid_in = valid_ff;
      rank_in = rank_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else begin
         if (cmd.evict && sel_evict) valid_in = 1'b0;
         if (cmd.refresh && valid_ff) begin
            if (match_any) begin
               if (sel_match) rank_in = '0;
               else if (rank_ff < ref_rank) rank_in = rank_ff + 1'b1;
            end else begin
               // insert: evicted cell had max rank, so all others age by one
               rank_in = rank_ff + 1'b1;
            end
         end
         if (cmd.insert && sel_insert) begin
            valid_in = 1'b1;
            rank_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rank_ff <= rank_in;
      if ((cmd.insert && sel_insert) || (cmd.update && sel_match)) begin
         dirty_ff <= dirty_new;
         data_ff <= data_new;
      end
      if (cmd.insert && sel_insert) id_ff <= key;
   end

   assign valid = valid_ff;
   assign rank = rank_ff;
   assign id = id_ff;
   assign dirty = dirty_ff;
   assign data = data_ff;
endmodule

// ----- hw/rtl/lru_writeback_cache_directory_top.sv -----
// Top level of the LRU write-back cache directory.
// Usage: request items arrive on req_ (tdata: node_id, dirty_in, data_in;
// tuser: kind). Each request yields one or more response items on rsp_
// (tdata: out_node_id, out_dirty, data_out, hit_count, access_count;
// tuser: action, hit; tlast marks the final response of a request).
// For gets and puts the accept cycle registers the request; once the
// response register is free, the key is compared against every cell at
// once, the cells are updated and the response register is loaded. A flush
// emits one response per stored entry, oldest first, one every cycle while
// the receiver keeps taking them, and a single response with no action for
// an empty store.
// One request is worked on at a time; the next is taken once its last
// response has been loaded, even while that response waits to be taken.
// A stalled receiver holds the response register and stops the block.
// Reset empties the directory, clears the counters, sets capacity to 16
// and selects disk as the eviction target. Configuration through csr_
// (capacity at 0x0, next level present at 0x4) while idle.
module lru_writeback_cache_directory_top
   import lwcd_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int ID_BITS = 32,
   parameter int DATA_BITS = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // node_id, dirty_in, data_in, zero fill
   input  logic [((ID_BITS+1+DATA_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_node_id, out_dirty, data_out, hit_count, access_count, zero fill
   output logic [((OUT_ID_BITS+1+DATA_BITS+64+7)/8)*8-1:0] rsp_tdata,
   // action, hit
   output logic [3:0] rsp_tuser,
   output logic rsp_tlast,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int RANK_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IDX_BITS = RANK_BITS;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int RSP_W = ((OUT_ID_BITS+1+DATA_BITS+64+7)/8)*8;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] kind_ff;
   logic [ID_BITS-1:0] key_ff;
   logic dirty_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [CFG_CAP_BITS-1:0] cap_cfg_ff;
   logic next_lvl_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [31:0] hits_ff, hits_in, acc_ff, acc_in;
   logic rsp_valid_ff;
   logic [2:0] r_act_ff;
   logic r_hit_ff, r_last_ff, r_dirty_ff;
   logic [OUT_ID_BITS-1:0] r_id_ff;
   logic [DATA_BITS-1:0] r_data_ff;
   logic [2:0] o_act;
   logic o_hit, o_last, o_dirty, o_load;
   logic [ID_BITS-1:0] o_id;
   logic [DATA_BITS-1:0] o_data;

   cell_cmd_type cmd;
   logic [CAPACITY-1:0] c_valid, c_match, sel_ins, sel_ev, sel_m;
   logic [RANK_BITS-1:0] c_rank [CAPACITY];
   logic [ID_BITS-1:0] c_id [CAPACITY];
   logic [CAPACITY-1:0] c_dirty;
   logic [DATA_BITS-1:0] c_data [CAPACITY];
   logic match_any, any_valid, full_lru;
   logic [IDX_BITS-1:0] m_idx, lru_idx;
   logic [RANK_BITS-1:0] m_rank;
   logic [CNT_BITS:0] cap_eff;
   logic is_zero_cap;

   wire csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2:2])
         1'b0: csr_prdata = 32'(cap_cfg_ff);
         default: csr_prdata = 32'(next_lvl_ff);
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_cfg_ff <= CFG_CAP_BITS'(16);
         next_lvl_ff <= 1'b0;
      end else if (csr_wr && csr_pready) begin
         if (csr_paddr[2:2] == REG_CAPACITY[0] && csr_paddr[1:0] == 2'b00)
            cap_cfg_ff <= csr_pwdata[CFG_CAP_BITS-1:0];
         else if (csr_paddr[2:2] == REG_NEXT_LEVEL[0] && csr_paddr[1:0] == 2'b00)
            next_lvl_ff <= csr_pwdata[0];
      end
   end

   assign cap_eff = (32'(cap_cfg_ff) > CAPACITY) ? (CNT_BITS+1)'(CAPACITY)
                                                 : (CNT_BITS+1)'(cap_cfg_ff);
   assign is_zero_cap = (cap_cfg_ff == '0);

   // cell selection: match index, oldest valid, first free
   always_comb begin
      m_idx = '0;
      lru_idx = '0;
      m_rank = '0;
      sel_ins = '0;
      sel_ev = '0;
      sel_m = '0;
      match_any = |c_match;
      any_valid = |c_valid;
      for (int i = 0; i < CAPACITY; i++) begin
         if (c_match[i]) begin
            m_idx = IDX_BITS'(i);
            m_rank = c_rank[i];
         end
         // oldest entry holds rank count-1
         if (c_valid[i] && 32'(c_rank[i]) == 32'(count_ff) - 1) lru_idx = IDX_BITS'(i);
      end
      sel_m[m_idx] = match_any;
      sel_ev[lru_idx] = any_valid;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!c_valid[i] || (cmd.evict && sel_ev[i])) sel_ins = CAPACITY'(1) << i;
      end
   end
   assign full_lru = any_valid && ((CNT_BITS+1)'(count_ff) >= cap_eff);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         lwcd_cell #(.ID_BITS(ID_BITS), .DATA_BITS(DATA_BITS), .RANK_BITS(RANK_BITS))
         u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .key(key_ff),
            .dirty_new(dirty_ff), .data_new(data_ff), .ref_rank(m_rank),
            .sel_insert(sel_ins[g]), .sel_evict(sel_ev[g]), .sel_match(sel_m[g]),
            .match_any(match_any), .valid(c_valid[g]), .match(c_match[g]),
            .rank(c_rank[g]), .id(c_id[g]), .dirty(c_dirty[g]), .data(c_data[g])
         );
      end
   endgenerate

   wire out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   wire req_acc = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      hits_in = hits_ff;
      acc_in = acc_ff;
      cmd = '0;
      o_load = 1'b0;
      o_act = ACT_NONE;
      o_hit = 1'b0;
      o_last = 1'b1;
      o_id = '0;
      o_dirty = 1'b0;
      o_data = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = (req_tuser == KIND_FLUSH) ? ST_FLUSH : ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               o_load = 1'b1;
               state_in = ST_IDLE;
               if (kind_ff != KIND_PUT) begin
                  o_act = ACT_FETCH;
                  o_id = key_ff;
                  if (!is_zero_cap) begin
                     acc_in = acc_ff + 32'd1;
                     if (match_any) begin
                        hits_in = hits_ff + 32'd1;
                        o_act = ACT_READ;
                        o_hit = 1'b1;
                        o_dirty = c_dirty[m_idx];
                        o_data = c_data[m_idx];
                        cmd.refresh = (kind_ff == KIND_GET_REFRESH);
                     end
                  end
               end else if (is_zero_cap) begin
                  o_id = key_ff;
                  o_dirty = dirty_ff;
                  o_data = data_ff;
                  if (next_lvl_ff) o_act = ACT_DEMOTE;
                  else if (dirty_ff) o_act = ACT_DISK;
                  else begin
                     o_id = '0;
                     o_data = '0;
                  end
               end else if (match_any) begin
                  cmd.update = 1'b1;
                  cmd.refresh = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  cmd.refresh = 1'b1;
                  if (full_lru) begin
                     cmd.evict = 1'b1;
                     o_id = c_id[lru_idx];
                     o_dirty = c_dirty[lru_idx];
                     o_data = c_data[lru_idx];
                     if (next_lvl_ff) o_act = ACT_DEMOTE;
                     else if (c_dirty[lru_idx]) o_act = ACT_DISK;
                     else begin
                        o_id = '0;
                        o_dirty = 1'b0;
                        o_data = '0;
                     end
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               o_load = 1'b1;
               if (any_valid) begin
                  o_act = ACT_DISK;
                  o_id = c_id[lru_idx];
                  o_dirty = c_dirty[lru_idx];
                  o_data = c_data[lru_idx];
                  cmd.evict = 1'b1;
                  count_in = count_ff - 1'b1;
                  o_last = (count_ff == CNT_BITS'(1));
               end
               if (o_last) begin
                  cmd.clear = 1'b1;
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         hits_ff <= '0;
         acc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hits_ff <= hits_in;
         acc_ff <= acc_in;
         if (o_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (req_acc) begin
         kind_ff <= req_tuser;
         key_ff <= req_tdata[ID_BITS-1:0];
         dirty_ff <= req_tdata[ID_BITS];
         data_ff <= req_tdata[ID_BITS+DATA_BITS:ID_BITS+1];
      end
      if (o_load) begin
         r_act_ff <= o_act;
         r_hit_ff <= o_hit;
         r_last_ff <= o_last;
         r_id_ff <= OUT_ID_BITS'(o_id);
         r_dirty_ff <= o_dirty;
         r_data_ff <= o_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = r_last_ff;
   assign rsp_tuser = {r_hit_ff, r_act_ff};
   assign rsp_tdata = RSP_W'({acc_ff, hits_ff, r_data_ff, r_dirty_ff, r_id_ff});

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY) else $error("entry count overflow");
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> 32'($countones(c_valid)) == 32'(count_ff))
      else $error("count out of step with valid cells");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");
   a_match_one: assert property (@(posedge clock) disable iff (reset)
      $onehot0(c_match)) else $error("duplicate ids");
`endif
endmodule
